@@ hdl/sha1c_pkg.sv @@
// Shared types and constants of the SHA-1 compression block.
// No dependencies; imported by the controller, the datapath and the top level.
package sha1c_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_WORDS  = 16;
    localparam int DIGEST_WORDS = 5;
    localparam int ROUNDS       = 80;
    localparam int CNT_W        = 4;
    localparam int ROUND_W      = 7;
    localparam int IDX_W        = 3;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t SHA1_IV [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t SHA1_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    typedef enum logic [1:0] {
        PH_CH     = 2'd0,
        PH_PARITY = 2'd1,
        PH_MAJ    = 2'd2,
        PH_PAR2   = 2'd3
    } phase_t;

    typedef struct packed {
        logic             load;
        logic             reload;
        logic             init;
        logic             round;
        logic             expand;
        phase_t           phase;
        logic             add;
        logic [IDX_W-1:0] out_idx;
    } sha1c_cmd_t;

endpackage

@@ hdl/sha1c_datapath.sv @@
// Datapath: message schedule shift line, round registers, chaining value.
// Depends on sha1c_pkg; driven by sha1c_ctrl through sha1c_cmd_t.
module sha1c_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha1c_pkg::sha1c_cmd_t cmd,
    input  sha1c_pkg::word_t      msg_word,
    output sha1c_pkg::word_t      digest_word
);
    import sha1c_pkg::*;

    word_t w_reg [BLOCK_WORDS];
    word_t chain_reg [DIGEST_WORDS];
    word_t a_reg, b_reg, c_reg, d_reg, e_reg;

    word_t w_exp, wt, shift_in, f_val, tmp;

    always_comb begin
        w_exp    = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        wt       = cmd.expand ? {w_exp[WORD_W-2:0], w_exp[WORD_W-1]} : w_reg[0];
        shift_in = cmd.load ? msg_word : wt;
        case (cmd.phase)
            PH_CH:   f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            PH_MAJ:  f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            default: f_val = b_reg ^ c_reg ^ d_reg;
        endcase
        tmp = {a_reg[WORD_W-6:0], a_reg[WORD_W-1:WORD_W-5]} + f_val + e_reg + wt
              + SHA1_K[cmd.phase];
    end

    // advance the schedule window on every loaded beat and every round
    always_ff @(posedge aclk) begin
        if (cmd.load || cmd.round) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[BLOCK_WORDS-1] <= shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                chain_reg[i] <= SHA1_IV[i];
            end
        end else if (cmd.reload) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                chain_reg[i] <= SHA1_IV[i];
            end
        end else if (cmd.add) begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            a_reg <= cmd.reload ? SHA1_IV[0] : chain_reg[0];
            b_reg <= cmd.reload ? SHA1_IV[1] : chain_reg[1];
            c_reg <= cmd.reload ? SHA1_IV[2] : chain_reg[2];
            d_reg <= cmd.reload ? SHA1_IV[3] : chain_reg[3];
            e_reg <= cmd.reload ? SHA1_IV[4] : chain_reg[4];
        end else if (cmd.round) begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[WORD_W-1:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    assign digest_word = (cmd.out_idx < IDX_W'(DIGEST_WORDS)) ? chain_reg[cmd.out_idx]
                                                              : chain_reg[0];

endmodule

@@ hdl/sha1c_ctrl.sv @@
// Controller: word counting, round sequencing and digest output beats.
// Depends on sha1c_pkg; commands sha1c_datapath through sha1c_cmd_t.
module sha1c_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_first_block,
    input  logic                         s_final_block,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sha1c_pkg::IDX_W-1:0]  m_word_index,
    output logic                         m_last_word,
    output sha1c_pkg::sha1c_cmd_t        cmd
);
    import sha1c_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_ROUND = 4'b0010,
        S_ADD   = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 final_reg, final_next;
    logic                 accept;

    assign s_ready      = (state_reg == S_LOAD);
    assign m_valid      = (state_reg == S_OUT);
    assign m_word_index = idx_reg;
    assign m_last_word  = (idx_reg == IDX_W'(DIGEST_WORDS - 1));
    assign accept       = s_valid && s_ready;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        final_next  = final_reg;

        cmd         = '0;
        cmd.out_idx = idx_reg;
        if (round_reg < ROUND_W'(20))      cmd.phase = PH_CH;
        else if (round_reg < ROUND_W'(40)) cmd.phase = PH_PARITY;
        else if (round_reg < ROUND_W'(60)) cmd.phase = PH_MAJ;
        else                               cmd.phase = PH_PAR2;

        unique case (state_reg)
            S_LOAD: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    cmd.reload = s_first_block;
                    cnt_next   = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(BLOCK_WORDS - 1)) begin
                        cmd.init   = 1'b1;
                        final_next = s_final_block;
                        round_next = '0;
                        state_next = S_ROUND;
                    end
                end
            end
            S_ROUND: begin
                cmd.round  = 1'b1;
                cmd.expand = (round_reg >= ROUND_W'(BLOCK_WORDS));
                round_next = round_reg + 1'b1;
                if (round_reg == ROUND_W'(ROUNDS - 1)) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                cmd.add    = 1'b1;
                idx_next   = '0;
                state_next = final_reg ? S_OUT : S_LOAD;
            end
            S_OUT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 1'b1;
                    if (m_last_word) begin
                        state_next = S_LOAD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            final_reg <= final_next;
        end
    end

endmodule

@@ hdl/sha1_compression_top.sv @@
// SHA-1 compression top level: joins the controller and the datapath.
// Depends on sha1c_pkg, sha1c_ctrl and sha1c_datapath.
//
// Feed padded message blocks as sixteen big-endian 32-bit words, one input beat
// per cycle while s_ready is high. s_first_block on any beat reloads the initial
// chaining value; s_final_block counts only on a block's sixteenth beat. After
// that beat s_ready drops while the 80 rounds run through the one round adder
// and the result is folded into the chaining value. A final block then
// presents five digest beats, H0 first, with m_last_word on the fifth; input
// stays stalled until they are all taken.
module sha1_compression_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sha1c_pkg::word_t             s_msg_word,
    input  logic                         s_first_block,
    input  logic                         s_final_block,
    output logic                         m_valid,
    input  logic                         m_ready,
    output sha1c_pkg::word_t             m_digest_word,
    output logic [sha1c_pkg::IDX_W-1:0]  m_word_index,
    output logic                         m_last_word
);
    import sha1c_pkg::*;

    sha1c_cmd_t cmd;

    sha1c_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_first_block (s_first_block),
        .s_final_block (s_final_block),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word),
        .cmd           (cmd)
    );

    sha1c_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .msg_word    (s_msg_word),
        .digest_word (m_digest_word)
    );

endmodule

@@ hdl/sha1c_checker.sv @@
// Port-level checks of the SHA-1 compression top level, with its bind.
// Depends on sha1c_pkg and sha1_compression_top.
module sha1c_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_ready,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  sha1c_pkg::word_t             m_digest_word,
    input  logic [sha1c_pkg::IDX_W-1:0]  m_word_index,
    input  logic                         m_last_word
);
    import sha1c_pkg::*;

    // hold a stalled digest beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digest_word)
                                && $stable(m_word_index))
        else $error("stalled digest beat changed");

    a_no_input_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while digest pending");

    a_index_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_word |=>
            m_valid && (m_word_index == IDX_W'($past(m_word_index) + 1'b1)))
        else $error("digest beats out of sequence");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_word == (m_word_index == IDX_W'(DIGEST_WORDS - 1))))
        else $error("last flag not on fifth digest beat");

    a_drop_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_word |=> !m_valid)
        else $error("digest beat after last");

endmodule

bind sha1_compression_top sha1c_checker u_sha1c_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_digest_word (m_digest_word),
    .m_word_index  (m_word_index),
    .m_last_word   (m_last_word)
);

@@ tb/sv/tb_sha1_compression_top.sv @@
// Testbench for sha1_compression_top: drives message blocks of random words and checks digest beats.
// Uses its own SHA-1 predictor for the expected digests; depends on sha1c_pkg and the RTL.
`timescale 1ns / 100ps

module tb_sha1_compression_top;
    import sha1c_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        word_t            digest;
        logic [IDX_W-1:0] idx;
        logic             last;
    } digest_beat_t;

    logic             aclk;
    logic             aresetn       = 1'b0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    word_t            s_msg_word    = '0;
    logic             s_first_block = 1'b0;
    logic             s_final_block = 1'b0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    word_t            m_digest_word;
    logic [IDX_W-1:0] m_word_index;
    logic             m_last_word;

    word_t            chain_h [DIGEST_WORDS];
    word_t            sched_w [BLOCK_WORDS];
    logic [CNT_W-1:0] words_held;
    digest_beat_t     digest_expected [$];
    digest_beat_t     want;

    int error_count   = 0;
    int idle_cycles   = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    bit send_idle_on  = 1'b1;
    bit rx_idle_on    = 1'b1;

    sha1_compression_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_msg_word    (s_msg_word),
        .s_first_block (s_first_block),
        .s_final_block (s_final_block),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic word_t rotl(word_t x, int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic void load_iv();
        for (int i = 0; i < DIGEST_WORDS; i++) chain_h[i] = SHA1_IV[i];
    endfunction

    function automatic void compress_block();
        word_t  w [BLOCK_WORDS];
        word_t  a, b, c, d, e, f, t;
        phase_t ph;
        int     r, s;
        for (r = 0; r < BLOCK_WORDS; r++) w[r] = sched_w[r];
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (r = 0; r < ROUNDS; r++) begin
            s = r % BLOCK_WORDS;
            if (r >= BLOCK_WORDS) begin
                w[s] = rotl(w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s], 1);
            end
            ph = phase_t'(r / 20);
            case (ph)
                PH_CH:   f = (b & c) | (~b & d);
                PH_MAJ:  f = (b & c) | (b & d) | (c & d);
                default: f = b ^ c ^ d;
            endcase
            t = rotl(a, 5) + f + e + w[s] + SHA1_K[r / 20];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void predict_digest(word_t word, logic first, logic fin);
        digest_beat_t beat;
        if (first) load_iv();
        sched_w[words_held] = word;
        words_held = words_held + 1'b1;
        if (words_held == '0) begin
            compress_block();
            if (fin) begin
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    beat.digest = chain_h[i];
                    beat.idx    = IDX_W'(i);
                    beat.last   = (i == DIGEST_WORDS - 1);
                    digest_expected.push_back(beat);
                end
            end
        end
    endfunction

    function automatic word_t rand_word();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return word_t'($urandom);
    endfunction

    task automatic send_msg_word(input word_t word, input logic first, input logic fin);
        if (send_idle_on) begin
            while ($urandom_range(99) < 33) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid       <= 1'b1;
        s_msg_word    <= word;
        s_first_block <= first;
        s_final_block <= fin;
        do @(posedge aclk); while (!s_ready);
        predict_digest(word, first, fin);
    endtask

    task automatic send_message(input int n_blocks, input bit with_first, input int first_pos,
                                input bit noisy);
        logic first, fin;
        bit   drop_final;
        drop_final = noisy && ($urandom_range(4) == 0);
        for (int b = 0; b < n_blocks; b++) begin
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                first = with_first && (b == 0) && (i == first_pos);
                fin   = (b == n_blocks - 1) && (i == BLOCK_WORDS - 1) && !drop_final;
                if (noisy) begin
                    if (i < BLOCK_WORDS - 1 && $urandom_range(4) == 0) fin = 1'b1;
                    if ($urandom_range(29) == 0) first = 1'b1;
                end
                send_msg_word(rand_word(), first, fin);
            end
        end
    endtask

    // no first flag after reset, final flag on every word, all-ones and all-zeros words
    task automatic test_extreme_words();
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            send_msg_word((i % 2 == 0) ? '1 : '0, 1'b0, 1'b1);
        end
    endtask

    task automatic test_random_messages();
        for (int m = 0; m < 4; m++) begin
            send_message($urandom_range(1, 2), 1'b1, 0, $urandom_range(3) == 0);
        end
    endtask

    task automatic test_mid_block_first();
        send_message(2, 1'b1, $urandom_range(1, BLOCK_WORDS - 1), 1'b0);
    endtask

    task automatic test_chain_after_final();
        send_message(1, 1'b1, 0, 1'b0);
        send_message(1, 1'b0, 0, 1'b0);
    endtask

    task automatic test_streaming_no_idle();
        send_idle_on = 1'b0;
        rx_idle_on   = 1'b0;
        for (int m = 0; m < 3; m++) send_message(1, 1'b1, 0, 1'b0);
        send_idle_on = 1'b1;
        rx_idle_on   = 1'b1;
    endtask

    task automatic test_output_backpressure();
        hold_requests++;
        for (int m = 0; m < 3; m++) send_message(1, 1'b1, 0, 1'b0);
    endtask

    always @(posedge aclk) begin
        if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (rx_idle_on) begin
            m_ready <= ($urandom_range(99) >= 33);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (digest_expected.size() == 0) begin
                $error("unexpected digest beat: digest_word %h word_index %0d",
                       m_digest_word, m_word_index);
                error_count++;
            end else begin
                want = digest_expected.pop_front();
                if (m_digest_word !== want.digest) begin
                    $error("digest_word: expected %h, actual %h", want.digest, m_digest_word);
                    error_count++;
                end
                if (m_word_index !== want.idx) begin
                    $error("word_index: expected %0d, actual %0d", want.idx, m_word_index);
                    error_count++;
                end
                if (m_last_word !== want.last) begin
                    $error("last_word: expected %0b, actual %0b", want.last, m_last_word);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[sha1_compression_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        load_iv();
        for (int i = 0; i < BLOCK_WORDS; i++) sched_w[i] = '0;
        words_held = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extreme_words();
        test_random_messages();
        test_mid_block_first();
        test_chain_after_final();
        test_streaming_no_idle();
        test_output_backpressure();
        test_random_messages();

        s_valid <= 1'b0;
        while (digest_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("[sha1_compression_top] OK");
        end else begin
            $display("[sha1_compression_top] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/sha1c_pkg.sv
hdl/sha1c_datapath.sv
hdl/sha1c_ctrl.sv
hdl/sha1_compression_top.sv
hdl/sha1c_checker.sv
tb/sv/tb_sha1_compression_top.sv
